// ----- rtl/lgft_pkg.sv -----
package lgft_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DUTY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    localparam logic [15:0] DUTY_RESET   = 16'd32768;
    localparam logic [14:0] LIFT_RESET   = 15'd1000;
    localparam logic [15:0] OFFSET_RESET = 16'd0;

    // Angles and CORDIC coordinates are Q30 in a 34-bit signed word.
    localparam int ANG_W = 34;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [31:0]             PI_Q30      = 32'd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;

    typedef logic signed [ANG_W-1:0] t_ang;

    function automatic t_ang lgft_atan(input int idx);
        t_ang v;
        case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/lgft_if.sv -----
interface lgft_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] time_now;
    logic [15:0] cycle_period;
    logic [15:0] stride_length;

    modport source (output valid, time_now, cycle_period, stride_length, input ready);
    modport sink   (input valid, time_now, cycle_period, stride_length, output ready);
endinterface

interface lgft_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] foot_x;
    logic [14:0]        foot_z;
    logic               in_stance;

    modport source (output valid, foot_x, foot_z, in_stance, input ready);
    modport sink   (input valid, foot_x, foot_z, in_stance, output ready);
endinterface

// ----- rtl/leg_gait_foot_trajectory.sv -----
// Throughput: one transaction per cycle while the output takes results; the pipeline has
// one stage per bit of the sum time + offset, one per quotient bit of the angle divider
// and one per CORDIC rotation.
// The whole pipeline holds while a finished result waits on the output.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
module leg_gait_foot_trajectory #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lgft_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lgft_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lgft_in_if.sink                        i_sample,
    lgft_out_if.source                     o_result
);
    import lgft_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int MODN  = 17;
    localparam int DIVN  = 32;

    logic [15:0] r_duty;
    logic [14:0] r_lift;
    logic [15:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty   <= DUTY_RESET;
            r_lift   <= LIFT_RESET;
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DUTY:   r_duty   <= i_cfg_data;
                CFG_LIFT:   r_lift   <= i_cfg_data[14:0];
                CFG_OFFSET: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_f_v;
    logic en;
    assign en = !r_f_v || o_result.ready;
    assign i_sample.ready = en;

    // Remainder of (time + offset) by the period, one bit per stage.
    logic        r_m_v   [0:MODN];
    logic [16:0] r_m_sum [0:MODN];
    logic [15:0] r_m_rem [0:MODN];
    logic [15:0] r_m_per [0:MODN];
    logic [15:0] r_m_s   [0:MODN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v[0] <= 1'b0;
        end else if (en) begin
            r_m_v[0] <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_sum[0] <= {1'b0, i_sample.time_now} + {1'b0, r_offset};
            r_m_rem[0] <= '0;
            r_m_per[0] <= i_sample.cycle_period;
            r_m_s[0]   <= i_sample.stride_length;
        end
    end

    for (genvar k = 0; k < MODN; k++) begin : g_mod
        logic [16:0] n_tmp;
        logic [16:0] n_sub;
        assign n_tmp = {r_m_rem[k], r_m_sum[k][MODN-1-k]};
        assign n_sub = n_tmp - {1'b0, r_m_per[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_v[k+1] <= 1'b0;
            end else if (en) begin
                r_m_v[k+1] <= r_m_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_m_sum[k+1] <= r_m_sum[k];
                r_m_rem[k+1] <= (n_tmp >= {1'b0, r_m_per[k]}) ? n_sub[15:0] : n_tmp[15:0];
                r_m_per[k+1] <= r_m_per[k];
                r_m_s[k+1]   <= r_m_s[k];
            end
        end
    end

    // Stage products: stance bound, swing denominator and stride times phase.
    logic        r1_v, r1_per0;
    logic [15:0] r1_phase, r1_s;
    logic [31:0] r1_bound, r1_den, r1_sp;
    logic        n1_per0;
    logic [15:0] n1_phase;
    logic [32:0] n1_den;

    assign n1_per0  = (r_m_per[MODN] == 16'd0);
    assign n1_phase = n1_per0 ? 16'd0 : r_m_rem[MODN];
    assign n1_den   = (17'h10000 - {1'b0, r_duty}) * r_m_per[MODN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r_m_v[MODN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_per0  <= n1_per0;
            r1_phase <= n1_phase;
            r1_s     <= r_m_s[MODN];
            r1_bound <= r_duty * r_m_per[MODN];
            r1_den   <= n1_den[31:0];
            r1_sp    <= r_m_s[MODN] * n1_phase;
        end
    end

    // Stance decision and divisor selection.
    logic        r2_v, r2_per0, r2_stance;
    logic [15:0] r2_s;
    logic [31:0] r2_u, r2_d, r2_sp;
    logic        n2_stance;

    assign n2_stance = r1_per0 || ({r1_phase, 16'h0} < r1_bound);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_per0   <= r1_per0;
            r2_stance <= n2_stance;
            r2_s      <= r1_s;
            r2_u      <= {r1_phase, 16'h0} - r1_bound;
            r2_d      <= n2_stance ? r1_bound : r1_den;
            r2_sp     <= r1_sp;
        end
    end

    // Dividend, then a restoring divider with one quotient bit per stage.
    // The quotient always fits 32 bits since the dividend is below divisor * 2^32.
    logic        r_d_v      [0:DIVN];
    logic        r_d_per0   [0:DIVN];
    logic        r_d_stance [0:DIVN];
    logic [15:0] r_d_s      [0:DIVN];
    logic [31:0] r_d_div    [0:DIVN];
    logic [31:0] r_d_rem    [0:DIVN];
    logic [31:0] r_d_nq     [0:DIVN];
    logic [63:0] n3_num;

    assign n3_num = r2_stance ? {15'd0, r2_sp, 17'd0} : r2_u * PI_Q30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v[0] <= 1'b0;
        end else if (en) begin
            r_d_v[0] <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_per0[0]   <= r2_per0;
            r_d_stance[0] <= r2_stance;
            r_d_s[0]      <= r2_s;
            r_d_div[0]    <= r2_d;
            r_d_rem[0]    <= n3_num[63:32];
            r_d_nq[0]     <= n3_num[31:0];
        end
    end

    for (genvar k = 0; k < DIVN; k++) begin : g_div
        logic [32:0] n_tmp;
        logic [32:0] n_sub;
        logic        n_ge;
        assign n_tmp = {r_d_rem[k], r_d_nq[k][31]};
        assign n_ge  = (n_tmp >= {1'b0, r_d_div[k]});
        assign n_sub = n_tmp - {1'b0, r_d_div[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_v[k+1] <= 1'b0;
            end else if (en) begin
                r_d_v[k+1] <= r_d_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d_per0[k+1]   <= r_d_per0[k];
                r_d_stance[k+1] <= r_d_stance[k];
                r_d_s[k+1]      <= r_d_s[k];
                r_d_div[k+1]    <= r_d_div[k];
                r_d_rem[k+1]    <= n_ge ? n_sub[31:0] : n_tmp[31:0];
                r_d_nq[k+1]     <= {r_d_nq[k][30:0], n_ge};
            end
        end
    end

    // Stance position is finished here; swing items start the CORDIC.
    logic        r_c_v      [0:NSTEP];
    logic        r_c_stance [0:NSTEP];
    logic [15:0] r_c_s      [0:NSTEP];
    logic [15:0] r_c_ox     [0:NSTEP];
    t_ang        r_c_x      [0:NSTEP];
    t_ang        r_c_y      [0:NSTEP];
    t_ang        r_c_z      [0:NSTEP];
    logic signed [17:0] nq_d;

    assign nq_d = r_d_per0[DIVN] ? -$signed({2'b0, r_d_s[DIVN]})
                : $signed({1'b0, r_d_nq[DIVN][16:0]}) - $signed({2'b0, r_d_s[DIVN]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v[0] <= 1'b0;
        end else if (en) begin
            r_c_v[0] <= r_d_v[DIVN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_stance[0] <= r_d_stance[DIVN];
            r_c_s[0]      <= r_d_s[DIVN];
            r_c_ox[0]     <= 16'(nq_d >>> 1);
            r_c_x[0]      <= GAIN_Q30;
            r_c_y[0]      <= '0;
            r_c_z[0]      <= $signed({2'b0, r_d_nq[DIVN]}) - HALF_PI_Q30;
        end
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
        t_ang n_dx, n_dy;
        assign n_dx = r_c_y[i] >>> i;
        assign n_dy = r_c_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_v[i+1] <= 1'b0;
            end else if (en) begin
                r_c_v[i+1] <= r_c_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c_stance[i+1] <= r_c_stance[i];
                r_c_s[i+1]      <= r_c_s[i];
                r_c_ox[i+1]     <= r_c_ox[i];
                if (!r_c_z[i][ANG_W-1]) begin
                    r_c_x[i+1] <= r_c_x[i] - n_dx;
                    r_c_y[i+1] <= r_c_y[i] + n_dy;
                    r_c_z[i+1] <= r_c_z[i] - lgft_atan(i);
                end else begin
                    r_c_x[i+1] <= r_c_x[i] + n_dx;
                    r_c_y[i+1] <= r_c_y[i] - n_dy;
                    r_c_z[i+1] <= r_c_z[i] + lgft_atan(i);
                end
            end
        end
    end

    // Scale by stride and lift.
    logic               r_p_v, r_p_stance;
    logic [15:0]        r_p_ox;
    logic signed [51:0] r_p_x, r_p_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= r_c_v[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_stance <= r_c_stance[NSTEP];
            r_p_ox     <= r_c_ox[NSTEP];
            r_p_x      <= (-r_c_y[NSTEP]) * $signed({1'b0, r_c_s[NSTEP]});
            r_p_z      <= r_c_x[NSTEP] * $signed({1'b0, r_lift});
        end
    end

    // Round, saturate and hold for the output handshake.
    logic signed [15:0] r_f_x;
    logic [14:0]        r_f_z;
    logic               r_f_stance;
    logic signed [51:0] n_fx, n_fz;
    logic signed [15:0] n_fx_sat;
    logic [14:0]        n_fz_sat;

    assign n_fx = (r_p_x + 52'sd1073741824) >>> 31;
    assign n_fz = (r_p_z + 52'sd536870912) >>> 30;
    assign n_fx_sat = (n_fx > 52'sd32767)  ? 16'sh7fff
                    : (n_fx < -52'sd32768) ? 16'sh8000 : n_fx[15:0];
    assign n_fz_sat = (n_fz > 52'sd32767) ? 15'h7fff
                    : (n_fz < 52'sd0)     ? 15'h0 : n_fz[14:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en) begin
            r_f_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_stance <= r_p_stance;
            r_f_x      <= r_p_stance ? r_p_ox : n_fx_sat;
            r_f_z      <= r_p_stance ? 15'h0 : n_fz_sat;
        end
    end

    assign o_result.valid     = r_f_v;
    assign o_result.foot_x    = r_f_x;
    assign o_result.foot_z    = r_f_z;
    assign o_result.in_stance = r_f_stance;

`ifndef ASSERT_OFF
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> r_m_v[0])
        else $error("accepted transaction did not enter the pipeline");

    a_phase_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_v[MODN] && (r_m_per[MODN] != 16'd0)) |-> (r_m_rem[MODN] < r_m_per[MODN]))
        else $error("phase not reduced");

    a_stance_zero_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_v && r_f_stance) |-> (r_f_z == 15'h0))
        else $error("stance result with nonzero height");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_p_v) && $stable(r_d_v[0]))
        else $error("pipeline advanced during a stall");
`endif

endmodule

// ----- bench/leg_gait_foot_trajectory_test.sv -----
module leg_gait_foot_trajectory_test;
    import lgft_pkg::*;

    localparam int STEPS        = 16;
    localparam int LATENCY      = 55 + STEPS;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 175;

    typedef struct packed {
        logic signed [15:0] x;
        logic [14:0]        z;
        logic               stance;
    } t_foot_pos;

    typedef struct packed {
        logic [15:0] t_now;
        logic [15:0] period;
        logic [15:0] stride;
        logic        typed;
        t_foot_pos   pos;
    } t_sample_row;

    // Samples at the reset settings (duty one half, lift 1000, no offset).
    // Rows marked typed carry an expected position that is plain from the
    // definition: zero period, zero phase, zero stride.
    localparam t_sample_row SAMPLE_ROWS [15] = '{
        '{16'd0,     16'd0,     16'd65535, 1'b1, '{-16'sd32768, 15'd0, 1'b1}},
        '{16'd65535, 16'd0,     16'd0,     1'b1, '{16'sd0,      15'd0, 1'b1}},
        '{16'd0,     16'd100,   16'd1000,  1'b1, '{-16'sd500,   15'd0, 1'b1}},
        '{16'd65535, 16'd1,     16'd65535, 1'b1, '{-16'sd32768, 15'd0, 1'b1}},
        '{16'd65535, 16'd65535, 16'd65535, 1'b1, '{-16'sd32768, 15'd0, 1'b1}},
        '{16'd0,     16'd65535, 16'd0,     1'b1, '{16'sd0,      15'd0, 1'b1}},
        '{16'd50,    16'd100,   16'd1000,  1'b0, '0},
        '{16'd75,    16'd100,   16'd1000,  1'b0, '0},
        '{16'd99,    16'd100,   16'd65535, 1'b0, '0},
        '{16'd49,    16'd100,   16'd65535, 1'b0, '0},
        '{16'd65534, 16'd65535, 16'd65535, 1'b0, '0},
        '{16'd32767, 16'd65535, 16'd0,     1'b0, '0},
        '{16'd12345, 16'd1000,  16'd40000, 1'b0, '0},
        '{16'hAAAA,  16'h5555,  16'hAAAA,  1'b0, '0},
        '{16'h5555,  16'hAAAA,  16'h5555,  1'b0, '0}
    };

    localparam longint ARCTAN_Q30 [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    lgft_in_if  sample_ch ();
    lgft_out_if result_ch ();

    leg_gait_foot_trajectory #(.CORDIC_STEPS(STEPS)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (sample_ch.sink),
        .o_result   (result_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // Settings as the block should hold them.
    logic [15:0] duty_q16;
    logic [14:0] lift_hundredths;
    logic [15:0] offset_ticks;

    t_foot_pos expected_pos_q[$];
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int mismatches;
    int results_seen;
    int swing_seen;
    int stance_seen;
    int quiet_cycles;

    function automatic t_foot_pos foot_position(logic [15:0] t_now, logic [15:0] period,
                                                logic [15:0] stride);
        longint unsigned phase, bound, scaled, den, u;
        longint d, theta, cx, cy, ang, dx, dy, fx, fz;
        t_foot_pos r;
        phase  = (period != 0) ? (64'(t_now) + 64'(offset_ticks)) % 64'(period) : 0;
        bound  = 64'(duty_q16) * 64'(period);
        scaled = phase << 16;
        r = '0;
        if (period == 0 || scaled < bound) begin
            if (period == 0)
                d = -longint'(stride);
            else
                d = longint'((2 * 64'(stride) * scaled) / bound) - longint'(stride);
            r.x = 16'(d >>> 1);
            r.stance = 1'b1;
        end else begin
            den   = (64'd65536 - 64'(duty_q16)) * 64'(period);
            u     = scaled - bound;
            theta = longint'((u * 64'(PI_Q30)) / den);
            // Rotating by theta - pi/2 gives sin(theta) on x and -cos(theta) on y.
            cx  = longint'(GAIN_Q30);
            cy  = 0;
            ang = theta - longint'(HALF_PI_Q30);
            for (int i = 0; i < STEPS && i < 24; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (ang >= 0) begin
                    cx -= dx; cy += dy; ang -= ARCTAN_Q30[i];
                end else begin
                    cx += dx; cy -= dy; ang += ARCTAN_Q30[i];
                end
            end
            fx = (-cy * longint'(stride) + (64'sd1 <<< 30)) >>> 31;
            fx = fx < -32768 ? -32768 : (fx > 32767 ? 32767 : fx);
            fz = (cx * longint'(lift_hundredths) + (64'sd1 <<< 29)) >>> 30;
            fz = fz < 0 ? 0 : (fz > 32767 ? 32767 : fz);
            r.x = 16'(fx);
            r.z = 15'(fz);
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (expected_pos_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] duty, logic [14:0] lift, logic [15:0] offset);
        wait_drained();
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_DUTY; i_cfg_data <= duty;
        @(posedge i_clk);
        i_cfg_idx <= CFG_LIFT; i_cfg_data <= 16'(lift);
        @(posedge i_clk);
        i_cfg_idx <= CFG_OFFSET; i_cfg_data <= offset;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        duty_q16 = duty;
        lift_hundredths = lift;
        offset_ticks = offset;
    endtask

    // Offer one sample; the transaction happens at the edge after a low-phase
    // sample of ready shows it high.
    task automatic send_sample(logic [15:0] t_now, logic [15:0] period, logic [15:0] stride,
                               bit typed, t_foot_pos typed_pos);
        bit taken;
        if ($urandom_range(99) < sender_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.time_now      <= t_now;
        sample_ch.cycle_period  <= period;
        sample_ch.stride_length <= stride;
        do begin
            @(negedge i_clk);
            taken = sample_ch.ready;
            @(posedge i_clk);
        end while (!taken);
        expected_pos_q.push_back(typed ? typed_pos : foot_position(t_now, period, stride));
    endtask

    task automatic random_sample();
        logic [15:0] period, stride;
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)      period = 16'($urandom_range(300, 1));
        else if (pick < 7) period = 16'($urandom_range(65535, 1));
        else if (pick < 8) period = 16'd0;
        else               period = $urandom_range(1) ? 16'd65535 : 16'd1;
        pick = $urandom_range(9);
        stride = pick == 0 ? 16'd0 : (pick == 1 ? 16'd65535 : 16'($urandom));
        send_sample(16'($urandom), period, stride, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            result_ch.ready <= 1'b0;
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(negedge i_clk) begin
        t_foot_pos want;
        if (i_rst_n) begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("** leg_gait_foot_trajectory: FAILED **");
                $finish;
            end
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (result_ch.in_stance) stance_seen++; else swing_seen++;
                if (expected_pos_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result x=%0d z=%0d stance=%0b",
                                 result_ch.foot_x, result_ch.foot_z, result_ch.in_stance);
                end else begin
                    want = expected_pos_q.pop_front();
                    if (result_ch.foot_x !== want.x || result_ch.foot_z !== want.z ||
                        result_ch.in_stance !== want.stance) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected x=%0d z=%0d stance=%0b,",
                                      " got x=%0d z=%0d stance=%0b"},
                                     results_seen, want.x, want.z, want.stance,
                                     result_ch.foot_x, result_ch.foot_z, result_ch.in_stance);
                    end
                end
            end
        end
    end

    initial begin
        logic [15:0] duty_set [N_PHASES];
        logic [14:0] lift_set [N_PHASES];
        logic [15:0] offset_set [N_PHASES];
        sample_ch.valid = 1'b0;
        sample_ch.time_now = '0;
        sample_ch.cycle_period = '0;
        sample_ch.stride_length = '0;
        result_ch.ready = 1'b0;
        sender_idle_pct = 16;
        receiver_idle_pct = 57;
        hold_requests = 0; hold_served = 0; hold_left = 0;
        mismatches = 0; results_seen = 0; swing_seen = 0; stance_seen = 0; quiet_cycles = 0;
        duty_q16 = DUTY_RESET;
        lift_hundredths = LIFT_RESET;
        offset_ticks = OFFSET_RESET;

        duty_set   = '{16'd0,    16'd65535, 16'd1,     16'd16384, 16'($urandom), 16'd49152};
        lift_set   = '{15'd32767, 15'd0,    15'd12345, 15'd1,     15'($urandom), 15'd32767};
        offset_set = '{16'd65535, 16'd1,    16'($urandom), 16'd0, 16'($urandom), 16'd32768};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (SAMPLE_ROWS[i])
            send_sample(SAMPLE_ROWS[i].t_now, SAMPLE_ROWS[i].period, SAMPLE_ROWS[i].stride,
                        SAMPLE_ROWS[i].typed, SAMPLE_ROWS[i].pos);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            sample_ch.valid <= 1'b0;
            set_config(duty_set[ph], lift_set[ph], offset_set[ph]);
            sender_idle_pct   = ph < 2 ? 16 : (ph < 4 ? 57 : 0);
            receiver_idle_pct = ph < 2 ? 57 : (ph < 4 ? 16 : 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Stall the output for a long stretch so the pipeline backs up.
                if (n == PHASE_ITEMS / 2 && (ph == 0 || ph == 4))
                    hold_requests++;
                random_sample();
            end
        end
        sample_ch.valid <= 1'b0;
        wait_drained();

        $display("covered %0d results (%0d stance, %0d swing) over %0d duty/lift/offset settings",
                 results_seen, stance_seen, swing_seen, N_PHASES + 1);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("** leg_gait_foot_trajectory: PASSED **");
        else
            $display("** leg_gait_foot_trajectory: FAILED **");
        $finish;
    end

endmodule
